FILE: sv/triangle_area_heron_3d_core_defines.svh
// assertion helpers for the asserting module
`ifndef TRIANGLE_AREA_HERON_3D_CORE_DEFINES_SVH
`define TRIANGLE_AREA_HERON_3D_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TAH3D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TAH3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tah3d_pkg.sv
package tah3d_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int AREA_W     = 41;

  // squared distance and side root
  localparam int D2_W     = 2 * COORD_BITS + 2;
  localparam int SRAD_RAW = D2_W + 2 * FRAC_BITS;
  localparam int SRAD_W   = SRAD_RAW + (SRAD_RAW % 2);
  localparam int SIDE_W   = SRAD_W / 2;

  // perimeter, factor products and area root
  localparam int P_W      = SIDE_W + 2;
  localparam int M_W      = 2 * P_W;
  localparam int PROD_W   = 4 * P_W;
  localparam int SHIFT_W  = 2 * FRAC_BITS + 4;
  localparam int ARAD_RAW = PROD_W - SHIFT_W;
  localparam int ARAD_W   = ARAD_RAW + (ARAD_RAW % 2);
  localparam int AROOT_W  = ARAD_W / 2;
  localparam int AEXT_W   = (AROOT_W > AREA_W) ? AROOT_W : AREA_W;

  // latencies in register stages
  localparam int SIDE_LAT = 3 + SIDE_W;
  localparam int PIPE_LAT = SIDE_LAT + 4 + AROOT_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [SIDE_W-1:0]            side_t;
  typedef logic [AREA_W-1:0]            area_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

FILE: sv/tah3d_side.sv
module tah3d_side import tah3d_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  point_t pt_p,
  input  point_t pt_q,
  output side_t  side
);

  localparam int W = SIDE_W;

  coord_t                       pc [3];
  coord_t                       qc [3];
  logic signed [COORD_BITS:0]   dif [3];
  logic [COORD_BITS-1:0]        mag_nxt [3];
  logic [COORD_BITS-1:0]        mag_r [3];
  logic [2*COORD_BITS-1:0]      sq_r [3];
  logic [D2_W-1:0]              d2_nxt;
  logic [SRAD_W-1:0]            rad_r;

  assign pc[0] = pt_p.x;
  assign pc[1] = pt_p.y;
  assign pc[2] = pt_p.z;
  assign qc[0] = pt_q.x;
  assign qc[1] = pt_q.y;
  assign qc[2] = pt_q.z;

  // absolute coordinate differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {qc[k][COORD_BITS-1], qc[k]} - {pc[k][COORD_BITS-1], pc[k]};
      mag_nxt[k] = dif[k][COORD_BITS] ? COORD_BITS'(-dif[k]) : COORD_BITS'(dif[k]);
    end
  end

  assign d2_nxt = D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag_nxt[k];
        sq_r[k]  <= (2*COORD_BITS)'(mag_r[k]) * (2*COORD_BITS)'(mag_r[k]);
      end
      rad_r <= SRAD_W'(d2_nxt) << (2 * FRAC_BITS);
    end
  end

  // restoring square root, one result bit per stage
  logic [W+1:0]   rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] num_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] num_in;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign num_in  = rad_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign num_in  = num_r[k-1];
    end

    assign cur   = {rem_in, num_in[2*W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[k]  <= (W+2)'(cur - trial);
          root_r[k] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur[W+1:0];
          root_r[k] <= {root_in[W-2:0], 1'b0};
        end
        num_r[k] <= num_in << 2;
      end
    end
  end

  assign side = root_r[W-1];

endmodule

FILE: sv/triangle_area_heron_3d_core.sv
// Heron triangle area for 3d integer points. One triangle per transaction goes in as nine
// signed coordinates, one area comes out with FRAC_BITS fraction bits, truncated; a triangle
// that collapses after side truncation gives zero. The pipeline takes a new transaction every
// cycle while the output is not stalled; the depth from input to output register is set mostly
// by the two bit-per-stage square-root pipelines (25 stages for the sides, 44 for the area). A
// stalled output freezes the whole pipeline; nothing is lost or repeated.
`include "triangle_area_heron_3d_core_defines.svh"

module triangle_area_heron_3d_core import tah3d_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_point_a_x,
  input  coord_t in_point_a_y,
  input  coord_t in_point_a_z,
  input  coord_t in_point_b_x,
  input  coord_t in_point_b_y,
  input  coord_t in_point_b_z,
  input  coord_t in_point_c_x,
  input  coord_t in_point_c_y,
  input  coord_t in_point_c_z,
  output logic   out_valid,
  input  logic   out_ready,
  output area_t  out_area
);

  localparam int W = AROOT_W;

  // valid bits ride alongside the data, one per stage
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  area_t               out_area_r;

  // global advance: the pipeline moves whenever the output register can take data
  logic pipe_en;
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  // side lengths |AB|, |BC|, |CA|
  point_t pa, pb, pc;
  side_t  side_a, side_b, side_c;

  assign pa = '{x: in_point_a_x, y: in_point_a_y, z: in_point_a_z};
  assign pb = '{x: in_point_b_x, y: in_point_b_y, z: in_point_b_z};
  assign pc = '{x: in_point_c_x, y: in_point_c_y, z: in_point_c_z};

  tah3d_side u_side_ab (.clk(clk), .en(pipe_en), .pt_p(pa), .pt_q(pb), .side(side_a));
  tah3d_side u_side_bc (.clk(clk), .en(pipe_en), .pt_p(pb), .pt_q(pc), .side(side_b));
  tah3d_side u_side_ca (.clk(clk), .en(pipe_en), .pt_p(pc), .pt_q(pa), .side(side_c));

  // stage a: perimeter p = 2s and the three factors p - 2x, kept signed
  logic [P_W-1:0]        per_nxt;
  logic [P_W-1:0]        per_r;
  logic signed [P_W:0]   fa_r, fb_r, fc_r;

  assign per_nxt = P_W'(side_a) + P_W'(side_b) + P_W'(side_c);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      per_r <= per_nxt;
      fa_r  <= $signed({1'b0, per_nxt}) - $signed({2'b00, side_a, 1'b0});
      fb_r  <= $signed({1'b0, per_nxt}) - $signed({2'b00, side_b, 1'b0});
      fc_r  <= $signed({1'b0, per_nxt}) - $signed({2'b00, side_c, 1'b0});
    end
  end

  // stage b: two pair products, degenerate flag when any factor went negative
  logic           degen_nxt;
  logic           degen_b_r;
  logic [M_W-1:0] m1_r, m2_r;

  assign degen_nxt = fa_r[P_W] || fb_r[P_W] || fc_r[P_W];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      degen_b_r <= degen_nxt;
      m1_r      <= M_W'(per_r) * M_W'(fa_r[P_W-1:0]);
      m2_r      <= M_W'(fb_r[P_W-1:0]) * M_W'(fc_r[P_W-1:0]);
    end
  end

  // stage c: the wide product split into four half-width partial products
  logic           degen_c_r;
  logic [M_W-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      degen_c_r <= degen_b_r;
      pp_ll_r   <= M_W'(m1_r[P_W-1:0])   * M_W'(m2_r[P_W-1:0]);
      pp_lh_r   <= M_W'(m1_r[P_W-1:0])   * M_W'(m2_r[M_W-1:P_W]);
      pp_hl_r   <= M_W'(m1_r[M_W-1:P_W]) * M_W'(m2_r[P_W-1:0]);
      pp_hh_r   <= M_W'(m1_r[M_W-1:P_W]) * M_W'(m2_r[M_W-1:P_W]);
    end
  end

  // stage d: recombine, divide by 16 and the fraction scale, clamp degenerate to zero
  logic [PROD_W-1:0] prod_nxt;
  logic [ARAD_W-1:0] arad_r;

  assign prod_nxt = PROD_W'(pp_ll_r)
                  + ((PROD_W'(pp_lh_r) + PROD_W'(pp_hl_r)) << P_W)
                  + (PROD_W'(pp_hh_r) << M_W);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      arad_r <= degen_c_r ? '0 : ARAD_W'(prod_nxt >> SHIFT_W);
    end
  end

  // area square root, one result bit per stage
  logic [W+1:0]   rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] num_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [W+1:0]   rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] num_in;
    logic [W+3:0]   cur;
    logic [W+3:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign num_in  = arad_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign num_in  = num_r[k-1];
    end

    assign cur   = {rem_in, num_in[2*W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (cur >= trial) begin
          rem_r[k]  <= (W+2)'(cur - trial);
          root_r[k] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur[W+1:0];
          root_r[k] <= {root_in[W-2:0], 1'b0};
        end
        num_r[k] <= num_in << 2;
      end
    end
  end

  // output register, saturating an area too wide for the port
  logic [AEXT_W-1:0] root_ext;
  assign root_ext = AEXT_W'(root_r[W-1]);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_area_r <= (|(root_ext >> AREA_W)) ? '1 : AREA_W'(root_ext);
    end
  end

  assign out_valid = out_valid_r;
  assign out_area  = out_area_r;

  // a collapsed triangle must reach the area root as a zero radicand
  `TAH3D_ASSERT_NEXT(a_degen_zero, pipe_en && degen_c_r, arad_r == '0,
    "degenerate triangle left a nonzero radicand")
  // a frozen pipeline keeps every valid bit in place
  `TAH3D_ASSERT_NEXT(a_stall_hold, !pipe_en, $stable(vld_r),
    "valid bits moved during a stall")
  // a result appears only from an item that reached the last stage
  `TAH3D_ASSERT_NOW(a_out_source, $rose(out_valid_r), $past(vld_r[PIPE_LAT-1]),
    "output valid without a finished item")

endmodule

FILE: sim/tb_triangle_area_heron_3d_core.sv
`timescale 1ns / 100ps

module tb_triangle_area_heron_3d_core;
  import tah3d_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_TRIS  = 1800;
  localparam int DRAIN_CYCLES = 120;   // drain time, longer than the pipeline latency
  localparam int HOLD_CYCLES  = 300;   // long out_ready hold-off, well past pipeline depth

  // expected areas of accepted triangles, oldest first, plus mismatch bookkeeping
  class area_scoreboard;
    area_t pending[$];
    int    errors;
    int    checked;
    int    zero_areas;

    function new();
      errors = 0;
      checked = 0;
      zero_areas = 0;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  root;
      logic [63:0]  cand;
      logic [127:0] sq;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
        cand = root | (64'd1 << i);
        sq = 128'(cand) * 128'(cand);
        if (sq <= n) root = cand;
      end
      return root;
    endfunction

    // truncated side length with FRAC_BITS fraction bits
    function automatic logic [63:0] side_len(point_t p, point_t q);
      longint       dx, dy, dz;
      logic [127:0] d2;
      dx = longint'(q.x) - longint'(p.x);
      dy = longint'(q.y) - longint'(p.y);
      dz = longint'(q.z) - longint'(p.z);
      d2 = 128'(dx * dx + dy * dy + dz * dz);
      return isqrt(d2 << (2 * FRAC_BITS));
    endfunction

    function automatic area_t heron_area(point_t pa, point_t pb, point_t pc);
      logic [127:0] a, b, c, perim, acc;
      logic [63:0]  root;
      a = 128'(side_len(pa, pb));
      b = 128'(side_len(pb, pc));
      c = 128'(side_len(pc, pa));
      perim = a + b + c;
      // truncated sides can break the triangle inequality: clamp to zero
      if (perim < 2 * a || perim < 2 * b || perim < 2 * c) return '0;
      acc = perim * (perim - 2 * a) * (perim - 2 * b) * (perim - 2 * c);
      root = isqrt(acc >> (2 * FRAC_BITS + 4));
      if (root > 64'((64'd1 << AREA_W) - 1)) return '1;
      return area_t'(root);
    endfunction

    function void note_triangle(point_t pa, point_t pb, point_t pc);
      pending.push_back(heron_area(pa, pb, pc));
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_area(area_t got);
      area_t want;
      if (pending.size() == 0) begin
        report($sformatf("area %0d with no triangle outstanding", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want == 0) zero_areas++;
      if (got !== want)
        report($sformatf("area got %0d expected %0d (result %0d)", got, want, checked));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_point_a_x, in_point_a_y, in_point_a_z;
  coord_t in_point_b_x, in_point_b_y, in_point_b_z;
  coord_t in_point_c_x, in_point_c_y, in_point_c_z;
  logic   out_valid;
  logic   out_ready;
  area_t  out_area;

  area_scoreboard sb = new();

  int  cycles = 0;
  bit  calm = 1'b0;        // no idling on either side while set
  bit  hold_req = 1'b0;    // sender asks the receiver for a long hold-off
  int  sent = 0;

  always #5 clk = ~clk;

  triangle_area_heron_3d_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_a_x (in_point_a_x),
    .in_point_a_y (in_point_a_y),
    .in_point_a_z (in_point_a_z),
    .in_point_b_x (in_point_b_x),
    .in_point_b_y (in_point_b_y),
    .in_point_b_z (in_point_b_z),
    .in_point_c_x (in_point_c_x),
    .in_point_c_y (in_point_c_y),
    .in_point_c_z (in_point_c_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_area     (out_area)
  );

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one triangle, with a random idle gap first, and hold it until accepted
  task send_triangle(point_t pa, point_t pb, point_t pc);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_point_a_x <= pa.x;
    in_point_a_y <= pa.y;
    in_point_a_z <= pa.z;
    in_point_b_x <= pb.x;
    in_point_b_y <= pb.y;
    in_point_b_z <= pb.z;
    in_point_c_x <= pc.x;
    in_point_c_y <= pc.y;
    in_point_c_z <= pc.z;
    @(posedge clk);
    // in_ready seen here is its value just before the edge
    while (!in_ready) @(posedge clk);
    sb.note_triangle(pa, pb, pc);
    sent++;
  endtask

  function automatic point_t rand_point();
    point_t p;
    p.x = coord_t'($urandom);
    p.y = coord_t'($urandom);
    p.z = coord_t'($urandom);
    return p;
  endfunction

  function automatic point_t pt(int x, int y, int z);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    return p;
  endfunction

  // small offset from a base point, wraps at the coordinate width
  function automatic point_t nudge(point_t base, int span);
    point_t p;
    p.x = coord_t'(base.x + $signed($urandom_range(2 * span)) - span);
    p.y = coord_t'(base.y + $signed($urandom_range(2 * span)) - span);
    p.z = coord_t'(base.z + $signed($urandom_range(2 * span)) - span);
    return p;
  endfunction

  // receiver: check every accepted area, then pick out_ready for the next cycle
  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (out_valid && out_ready && rst_n) sb.check_area(out_area);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
      @(posedge clk);
    end
  end

  initial begin
    point_t a, b, c, d;
    int     kind;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_point_a_x <= '0;
    in_point_a_y <= '0;
    in_point_a_z <= '0;
    in_point_b_x <= '0;
    in_point_b_y <= '0;
    in_point_b_z <= '0;
    in_point_c_x <= '0;
    in_point_c_y <= '0;
    in_point_c_z <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: coincident points, extremes, right and collinear triangles
    send_triangle(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
    send_triangle(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                  pt(-32768, -32768, -32768));
    send_triangle(pt(32767, 32767, 32767), pt(-32768, -32768, -32768),
                  pt(32767, -32768, 32767));
    send_triangle(pt(-32768, -32768, -32768), pt(32767, 32767, -32768),
                  pt(32767, -32768, 32767));
    send_triangle(pt(-32768, 32767, 0), pt(32767, -32768, 0), pt(0, 0, 32767));
    send_triangle(pt(-32768, -32768, 0), pt(32767, -32768, 0), pt(-32768, 32767, 0));
    send_triangle(pt(0, 0, 0), pt(3, 0, 0), pt(0, 4, 0));
    send_triangle(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0));
    send_triangle(pt(0, 0, 0), pt(1, 1, 1), pt(2, 2, 2));        // collinear
    send_triangle(pt(-32768, 0, 0), pt(0, 0, 0), pt(32767, 0, 0));
    send_triangle(pt(-1, -1, -1), pt(1, 1, 1), pt(3, 3, 4));     // nearly flat
    send_triangle(pt(0, 0, 0), pt(1, 0, 0), pt(2, 1, 0));
    send_triangle(pt(5, 5, 5), pt(5, 5, 5), pt(9, -3, 7));       // two points shared
    send_triangle(pt(32767, 0, -32768), pt(-32768, 0, 32767), pt(0, 32767, 0));
    send_triangle(pt(100, 200, 300), pt(-400, 500, -600), pt(700, -800, 900));
    for (int i = 0; i < 5; i++) send_triangle(rand_point(), rand_point(), rand_point());

    for (int i = 0; i < RANDOM_TRIS; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1100) hold_req = 1'b1;
      kind = $urandom_range(9);
      a = rand_point();
      case (kind)
        0, 1, 2, 3: begin
          b = rand_point();
          c = rand_point();
        end
        4, 5: begin
          b = nudge(a, 8);
          c = nudge(a, 8);
        end
        6, 7: begin
          // collinear or almost, the clamp-to-zero path
          d = pt($signed($urandom_range(200)) - 100, $signed($urandom_range(200)) - 100,
                 $signed($urandom_range(200)) - 100);
          b = pt(a.x + d.x, a.y + d.y, a.z + d.z);
          c = pt(a.x + 2 * d.x + $signed($urandom_range(2)) - 1, a.y + 2 * d.y,
                 a.z + 2 * d.z);
        end
        8: begin
          b = a;
          c = nudge(a, 1000);
        end
        default: begin
          b = nudge(a, 2000);
          c = nudge(b, 2000);
        end
      endcase
      send_triangle(a, b, c);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d triangles, checked %0d areas (%0d zero, degenerate or coincident)",
             sent, sb.checked, sb.zero_areas);
    $display("covered extreme coordinates, collinear sets, random idling and a long stall");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
